/* src/cdlf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdlf_pkg
// Shared types, constants and helpers of the clock drift linear fit block.
// ----------------------------------------------------------------------------
package cdlf_pkg;

    localparam int WIDE_W        = 256;
    localparam int LIMB_W        = 32;
    localparam int LIMBS         = WIDE_W / LIMB_W;
    localparam int LIMB_IW       = 3;
    localparam int LIMB_CW       = 4;
    localparam int TICK_W        = 32;
    localparam int TIME_W        = 48;
    localparam int EXT_W         = 63;
    localparam int DIFF_W        = 64;
    localparam int OUT_W         = 64;
    localparam int OFF_FRAC_BITS = 16;
    localparam int MIN_SAMPLES   = 3;

    localparam logic [1:0] FIT_VALID    = 2'd0;
    localparam logic [1:0] FIT_FEW      = 2'd1;
    localparam logic [1:0] FIT_SINGULAR = 2'd2;

    typedef logic [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic [EXT_W-1:0]  ext;
        logic [DIFF_W-1:0] diff;
    } t_sample;

    function automatic t_wide wide_abs(t_wide a);
        t_wide neg;
        neg = t_wide'(-a);
        return a[WIDE_W-1] ? neg : a;
    endfunction

    function automatic logic [OUT_W-1:0] sat64(t_wide a);
        logic [WIDE_W-OUT_W:0] top;
        top = a[WIDE_W-1:OUT_W-1];
        if (top == {(WIDE_W-OUT_W+1){a[OUT_W-1]}}) begin
            return a[OUT_W-1:0];
        end else if (a[WIDE_W-1]) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

endpackage

/* src/clock_drift_linear_fit.sv */
// Each item walks the filled entries of the ring (up to DEPTH) through the shared
// 32x32 limb multiplier, then forms the normal equations and divides on the
// bit-serial 256-bit divider; while fewer than three samples are held, both are
// skipped. One item is fitted at a time; a two-entry input queue and a result
// register decouple the sides. Reset clears wrap tracking, pointers, count and
// queues, not the ring.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_drift_linear_fit
// Least-squares fit of reference time minus extended tick against tick.
// ----------------------------------------------------------------------------
module clock_drift_linear_fit #(
    parameter int DEPTH           = 32,
    parameter int SLOPE_FRAC_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic        [cdlf_pkg::TICK_W-1:0] i_tick,
    input  logic        [cdlf_pkg::TIME_W-1:0] i_time_us,
    output logic                               empty,
    input  logic                               pop,
    output logic        [cdlf_pkg::EXT_W-1:0]  o_extended_tick,
    output logic signed [cdlf_pkg::OUT_W-1:0]  o_slope_fixed,
    output logic signed [cdlf_pkg::OUT_W-1:0]  o_offset_fixed,
    output logic        [1:0]                  o_fit_status
);

    logic              w_q_valid;
    logic              w_q_pop;
    cdlf_pkg::t_sample w_q_item;

    cdlf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_tick    (i_tick),
        .i_time_us (i_time_us),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_item  (w_q_item)
    );

    cdlf_back #(
        .DEPTH           (DEPTH),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .o_q_pop         (w_q_pop),
        .i_q_item        (w_q_item),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_extended_tick (o_extended_tick),
        .o_slope_fixed   (o_slope_fixed),
        .o_offset_fixed  (o_offset_fixed),
        .o_fit_status    (o_fit_status)
    );

endmodule

/* src/cdlf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdlf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cdlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/cdlf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdlf_front
// Widens the raw tick using a wrap count, forms time minus tick, and holds
// the items in a two-entry queue toward the fit engine.
// ----------------------------------------------------------------------------
module cdlf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [cdlf_pkg::TICK_W-1:0]  i_tick,
    input  logic [cdlf_pkg::TIME_W-1:0]  i_time_us,
    output logic                         o_q_valid,
    input  logic                         i_q_pop,
    output cdlf_pkg::t_sample            o_q_item
);

    localparam logic [1:0] Q_FULL = 2'd2;

    logic [cdlf_pkg::TICK_W-1:0] r_prev;
    logic [cdlf_pkg::TICK_W-1:0] r_wrap;
    logic [cdlf_pkg::TICK_W-1:0] n_wrap;
    cdlf_pkg::t_sample           r_slot [2];
    cdlf_pkg::t_sample           w_item;
    logic                        r_rd_ptr;
    logic [1:0]                  r_cnt;
    logic                        w_accept;
    logic                        w_wr_ptr;

    assign o_full    = (r_cnt == Q_FULL);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_slot[r_rd_ptr];
    assign w_accept  = i_push && !o_full;
    assign w_wr_ptr  = r_rd_ptr ^ r_cnt[0];

    always_comb begin
        n_wrap      = (i_tick < r_prev) ? r_wrap + 1'b1 : r_wrap;
        w_item.ext  = {n_wrap[cdlf_pkg::EXT_W-cdlf_pkg::TICK_W-1:0], i_tick};
        w_item.diff = cdlf_pkg::DIFF_W'(i_time_us) - cdlf_pkg::DIFF_W'(w_item.ext);
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot[w_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_wrap   <= '0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_accept) begin
                r_prev <= i_tick;
                r_wrap <= n_wrap;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_accept, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* src/cdlf_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdlf_mul
// Sequential 256-bit two's complement multiplier, modulo 2^256. Works on
// magnitudes, one 32x32 limb product per cycle, skipping zero top limbs.
// ----------------------------------------------------------------------------
module cdlf_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  cdlf_pkg::t_wide i_a,
    input  cdlf_pkg::t_wide i_b,
    output logic            o_done,
    output cdlf_pkg::t_wide o_p
);

    typedef enum logic [4:0] {
        M_IDLE  = 5'b00001,
        M_LEN   = 5'b00010,
        M_RUN   = 5'b00100,
        M_DRAIN = 5'b01000,
        M_SIGN  = 5'b10000
    } t_mstate;

    t_mstate                        r_state;
    cdlf_pkg::t_wide                r_ma;
    cdlf_pkg::t_wide                r_mb;
    cdlf_pkg::t_wide                r_acc;
    cdlf_pkg::t_wide                r_p;
    logic                           r_neg;
    logic                           r_done;
    logic [cdlf_pkg::LIMB_CW-1:0]   r_la;
    logic [cdlf_pkg::LIMB_CW-1:0]   r_lb;
    logic [cdlf_pkg::LIMB_CW-1:0]   n_la;
    logic [cdlf_pkg::LIMB_CW-1:0]   n_lb;
    logic [cdlf_pkg::LIMB_IW-1:0]   r_i;
    logic [cdlf_pkg::LIMB_IW-1:0]   r_j;
    logic [cdlf_pkg::LIMB_IW-1:0]   r_pk;
    logic [2*cdlf_pkg::LIMB_W-1:0]  r_pp;
    logic                           r_ppv;
    logic [cdlf_pkg::LIMB_W-1:0]    w_limb_a;
    logic [cdlf_pkg::LIMB_W-1:0]    w_limb_b;
    logic                           w_j_more;
    logic                           w_i_more;

    always_comb begin
        n_la = cdlf_pkg::LIMB_CW'(1);
        n_lb = cdlf_pkg::LIMB_CW'(1);
        for (int k = 0; k < cdlf_pkg::LIMBS; k++) begin
            if (r_ma[k*cdlf_pkg::LIMB_W +: cdlf_pkg::LIMB_W] != '0) begin
                n_la = cdlf_pkg::LIMB_CW'(k + 1);
            end
            if (r_mb[k*cdlf_pkg::LIMB_W +: cdlf_pkg::LIMB_W] != '0) begin
                n_lb = cdlf_pkg::LIMB_CW'(k + 1);
            end
        end
    end

    assign w_limb_a = r_ma[r_i*cdlf_pkg::LIMB_W +: cdlf_pkg::LIMB_W];
    assign w_limb_b = r_mb[r_j*cdlf_pkg::LIMB_W +: cdlf_pkg::LIMB_W];
    assign w_j_more = (({1'b0, r_j} + cdlf_pkg::LIMB_CW'(1)) < r_lb) &&
                      (({1'b0, r_i} + {1'b0, r_j} + cdlf_pkg::LIMB_CW'(1))
                       < cdlf_pkg::LIMB_CW'(cdlf_pkg::LIMBS));
    assign w_i_more = ({1'b0, r_i} + cdlf_pkg::LIMB_CW'(1)) < r_la;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_ppv   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_ppv) begin
                r_acc <= r_acc + (cdlf_pkg::t_wide'(r_pp) << (r_pk * cdlf_pkg::LIMB_W));
            end
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_ma    <= cdlf_pkg::wide_abs(i_a);
                        r_mb    <= cdlf_pkg::wide_abs(i_b);
                        r_neg   <= i_a[cdlf_pkg::WIDE_W-1] ^ i_b[cdlf_pkg::WIDE_W-1];
                        r_acc   <= '0;
                        r_state <= M_LEN;
                    end
                end
                M_LEN: begin
                    r_la    <= n_la;
                    r_lb    <= n_lb;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_state <= M_RUN;
                end
                M_RUN: begin
                    r_pp  <= w_limb_a * w_limb_b;
                    r_pk  <= r_i + r_j;
                    r_ppv <= 1'b1;
                    if (w_j_more) begin
                        r_j <= r_j + 1'b1;
                    end else if (w_i_more) begin
                        r_i <= r_i + 1'b1;
                        r_j <= '0;
                    end else begin
                        r_state <= M_DRAIN;
                    end
                end
                M_DRAIN: begin
                    r_ppv   <= 1'b0;
                    r_state <= M_SIGN;
                end
                M_SIGN: begin
                    r_p     <= r_neg ? cdlf_pkg::t_wide'(-r_acc) : r_acc;
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

/* src/cdlf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdlf_div
// Bit-serial 256-bit signed divider, restoring, truncating toward zero.
// ----------------------------------------------------------------------------
module cdlf_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  cdlf_pkg::t_wide i_num,
    input  cdlf_pkg::t_wide i_den,
    output logic            o_done,
    output cdlf_pkg::t_wide o_q
);

    localparam int CW = $clog2(cdlf_pkg::WIDE_W);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_SIGN = 3'b100
    } t_dstate;

    t_dstate         r_state;
    cdlf_pkg::t_wide r_num;
    cdlf_pkg::t_wide r_den;
    cdlf_pkg::t_wide r_rem;
    cdlf_pkg::t_wide r_q;
    logic            r_qneg;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    cdlf_pkg::t_wide w_rem_sh;
    cdlf_pkg::t_wide w_rem_sub;
    logic            w_ge;

    assign w_rem_sh  = {r_rem[cdlf_pkg::WIDE_W-2:0], r_num[cdlf_pkg::WIDE_W-1]};
    assign w_ge      = (w_rem_sh >= r_den);
    assign w_rem_sub = w_rem_sh - r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_num   <= cdlf_pkg::wide_abs(i_num);
                        r_den   <= cdlf_pkg::wide_abs(i_den);
                        r_qneg  <= i_num[cdlf_pkg::WIDE_W-1] ^ i_den[cdlf_pkg::WIDE_W-1];
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= w_ge ? w_rem_sub : w_rem_sh;
                    r_num <= {r_num[cdlf_pkg::WIDE_W-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(cdlf_pkg::WIDE_W - 1)) begin
                        r_state <= D_SIGN;
                    end
                end
                D_SIGN: begin
                    r_q     <= r_qneg ? cdlf_pkg::t_wide'(-r_num) : r_num;
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

/* src/cdlf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdlf_back
// Fit engine: stores each item in the sample ring, walks the filled entries
// accumulating anchored sums, forms the normal equations and divides.
// ----------------------------------------------------------------------------
module cdlf_back #(
    parameter int DEPTH           = 32,
    parameter int SLOPE_FRAC_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    output logic                               o_q_pop,
    input  cdlf_pkg::t_sample                  i_q_item,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic        [cdlf_pkg::EXT_W-1:0]  o_extended_tick,
    output logic signed [cdlf_pkg::OUT_W-1:0]  o_slope_fixed,
    output logic signed [cdlf_pkg::OUT_W-1:0]  o_offset_fixed,
    output logic        [1:0]                  o_fit_status
);

    localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int RAM_W = cdlf_pkg::EXT_W + cdlf_pkg::DIFF_W;
    localparam int DX_W  = cdlf_pkg::DIFF_W + 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_READ  = 10'b0000000010,
        S_DIFF  = 10'b0000000100,
        S_MGO   = 10'b0000001000,
        S_MWAIT = 10'b0000010000,
        S_CHECK = 10'b0000100000,
        S_DGO   = 10'b0001000000,
        S_DWAIT = 10'b0010000000,
        S_SAT   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    typedef enum logic [2:0] {
        MOP_XX   = 3'd0,
        MOP_XY   = 3'd1,
        MOP_NXX  = 3'd2,
        MOP_SXSX = 3'd3,
        MOP_NXY  = 3'd4,
        MOP_SXSY = 3'd5,
        MOP_SYXX = 3'd6,
        MOP_SXXY = 3'd7
    } t_mop;

    function automatic cdlf_pkg::t_wide sext_dx(logic [DX_W-1:0] v);
        return {{(cdlf_pkg::WIDE_W-DX_W){v[DX_W-1]}}, v};
    endfunction

    t_state                        r_state;
    t_mop                          r_mop;
    logic                          r_dop;
    logic [IDXW-1:0]               r_wr_idx;
    logic [IDXW-1:0]               r_rd;
    logic [CNTW-1:0]               r_count;
    logic [CNTW-1:0]               n_count;
    logic [CNTW-1:0]               r_n;
    logic [cdlf_pkg::EXT_W-1:0]    r_ax;
    logic [cdlf_pkg::DIFF_W-1:0]   r_ay;
    logic [cdlf_pkg::EXT_W-1:0]    r_ext;
    logic [DX_W-1:0]               r_dx;
    logic [DX_W-1:0]               r_dy;
    cdlf_pkg::t_wide               r_sx;
    cdlf_pkg::t_wide               r_sy;
    cdlf_pkg::t_wide               r_sxx;
    cdlf_pkg::t_wide               r_sxy;
    cdlf_pkg::t_wide               r_denom;
    cdlf_pkg::t_wide               r_numm;
    cdlf_pkg::t_wide               r_numb;
    cdlf_pkg::t_wide               r_bsum;
    logic [cdlf_pkg::OUT_W-1:0]    r_slope;
    logic [cdlf_pkg::OUT_W-1:0]    r_offset;
    logic [1:0]                    r_status;
    logic                          r_o_valid;
    logic [cdlf_pkg::EXT_W-1:0]    r_o_ext;
    logic [cdlf_pkg::OUT_W-1:0]    r_o_slope;
    logic [cdlf_pkg::OUT_W-1:0]    r_o_offset;
    logic [1:0]                    r_o_status;

    logic                          w_we;
    logic                          w_re;
    logic [RAM_W-1:0]              w_wdata;
    logic [RAM_W-1:0]              w_rdata;
    logic [cdlf_pkg::EXT_W-1:0]    w_rd_ext;
    logic [cdlf_pkg::DIFF_W-1:0]   w_rd_diff;
    logic [DX_W-1:0]               w_dx;
    logic [DX_W-1:0]               w_dy;
    logic                          w_last;
    logic                          w_out_free;
    cdlf_pkg::t_wide               w_ay_wide;
    cdlf_pkg::t_wide               w_mul_a;
    cdlf_pkg::t_wide               w_mul_b;
    cdlf_pkg::t_wide               w_mul_p;
    logic                          w_mul_done;
    cdlf_pkg::t_wide               w_div_num;
    cdlf_pkg::t_wide               w_div_q;
    logic                          w_div_done;

    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign w_we       = o_q_pop;
    assign w_re       = (r_state == S_READ);
    assign w_wdata    = {i_q_item.ext, i_q_item.diff};
    assign w_rd_ext   = w_rdata[RAM_W-1:cdlf_pkg::DIFF_W];
    assign w_rd_diff  = w_rdata[cdlf_pkg::DIFF_W-1:0];
    assign w_dx       = {2'b00, w_rd_ext} - {2'b00, r_ax};
    assign w_dy       = {w_rd_diff[cdlf_pkg::DIFF_W-1], w_rd_diff}
                      - {r_ay[cdlf_pkg::DIFF_W-1], r_ay};
    assign n_count    = (r_count < CNTW'(DEPTH)) ? r_count + 1'b1 : r_count;
    assign w_last     = ((CNTW'(r_rd) + CNTW'(1)) == r_n);
    assign w_out_free = !r_o_valid || i_pop;
    assign w_ay_wide  = {{(cdlf_pkg::WIDE_W-cdlf_pkg::DIFF_W){r_ay[cdlf_pkg::DIFF_W-1]}}, r_ay};
    assign w_div_num  = r_dop ? (r_numb << cdlf_pkg::OFF_FRAC_BITS)
                              : (r_numm << SLOPE_FRAC_BITS);

    always_comb begin
        case (r_mop)
            MOP_XX:   begin w_mul_a = sext_dx(r_dx);                 w_mul_b = sext_dx(r_dx); end
            MOP_XY:   begin w_mul_a = sext_dx(r_dx);                 w_mul_b = sext_dx(r_dy); end
            MOP_NXX:  begin w_mul_a = cdlf_pkg::t_wide'(r_n);        w_mul_b = r_sxx;         end
            MOP_SXSX: begin w_mul_a = r_sx;                          w_mul_b = r_sx;          end
            MOP_NXY:  begin w_mul_a = cdlf_pkg::t_wide'(r_n);        w_mul_b = r_sxy;         end
            MOP_SXSY: begin w_mul_a = r_sx;                          w_mul_b = r_sy;          end
            MOP_SYXX: begin w_mul_a = r_sy;                          w_mul_b = r_sxx;         end
            MOP_SXXY: begin w_mul_a = r_sx;                          w_mul_b = r_sxy;         end
            default:  begin w_mul_a = '0;                            w_mul_b = '0;            end
        endcase
    end

    cdlf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr_idx),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rd),
        .o_rdata (w_rdata)
    );

    cdlf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MGO),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    cdlf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DGO),
        .i_num   (w_div_num),
        .i_den   (r_denom),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wr_idx  <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_mop     <= MOP_XX;
            r_dop     <= 1'b0;
        end else begin
            if (i_pop && r_o_valid && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_wr_idx <= (r_wr_idx == IDXW'(DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
                        r_count  <= n_count;
                        r_n      <= n_count;
                        r_ax     <= i_q_item.ext;
                        r_ay     <= i_q_item.diff;
                        r_ext    <= i_q_item.ext;
                        r_sx     <= '0;
                        r_sy     <= '0;
                        r_sxx    <= '0;
                        r_sxy    <= '0;
                        r_rd     <= '0;
                        if (n_count < CNTW'(cdlf_pkg::MIN_SAMPLES)) begin
                            r_slope  <= '0;
                            r_offset <= '0;
                            r_status <= cdlf_pkg::FIT_FEW;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_dx    <= w_dx;
                    r_dy    <= w_dy;
                    r_sx    <= r_sx + sext_dx(w_dx);
                    r_sy    <= r_sy + sext_dx(w_dy);
                    r_mop   <= MOP_XX;
                    r_state <= S_MGO;
                end
                S_MGO: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_mul_done) begin
                        r_state <= S_MGO;
                        case (r_mop)
                            MOP_XX: begin
                                r_sxx <= r_sxx + w_mul_p;
                                r_mop <= MOP_XY;
                            end
                            MOP_XY: begin
                                r_sxy <= r_sxy + w_mul_p;
                                if (w_last) begin
                                    r_mop <= MOP_NXX;
                                end else begin
                                    r_rd    <= r_rd + 1'b1;
                                    r_state <= S_READ;
                                end
                            end
                            MOP_NXX: begin
                                r_denom <= w_mul_p;
                                r_mop   <= MOP_SXSX;
                            end
                            MOP_SXSX: begin
                                r_denom <= r_denom - w_mul_p;
                                r_mop   <= MOP_NXY;
                            end
                            MOP_NXY: begin
                                r_numm <= w_mul_p;
                                r_mop  <= MOP_SXSY;
                            end
                            MOP_SXSY: begin
                                r_numm <= r_numm - w_mul_p;
                                r_mop  <= MOP_SYXX;
                            end
                            MOP_SYXX: begin
                                r_numb <= w_mul_p;
                                r_mop  <= MOP_SXXY;
                            end
                            MOP_SXXY: begin
                                r_numb  <= r_numb - w_mul_p;
                                r_state <= S_CHECK;
                            end
                            default: r_state <= S_CHECK;
                        endcase
                    end
                end
                S_CHECK: begin
                    if (r_denom == '0) begin
                        r_slope  <= '0;
                        r_offset <= '0;
                        r_status <= cdlf_pkg::FIT_SINGULAR;
                        r_state  <= S_DONE;
                    end else begin
                        r_dop   <= 1'b0;
                        r_state <= S_DGO;
                    end
                end
                S_DGO: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        if (!r_dop) begin
                            r_slope <= cdlf_pkg::sat64(w_div_q);
                            r_dop   <= 1'b1;
                            r_state <= S_DGO;
                        end else begin
                            r_bsum  <= w_div_q + (w_ay_wide << cdlf_pkg::OFF_FRAC_BITS);
                            r_state <= S_SAT;
                        end
                    end
                end
                S_SAT: begin
                    r_offset <= cdlf_pkg::sat64(r_bsum);
                    r_status <= cdlf_pkg::FIT_VALID;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_ext    <= r_ext;
                        r_o_slope  <= r_slope;
                        r_o_offset <= r_offset;
                        r_o_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty         = !r_o_valid;
    assign o_extended_tick = r_o_ext;
    assign o_slope_fixed   = r_o_slope;
    assign o_offset_fixed  = r_o_offset;
    assign o_fit_status    = r_o_status;

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("queue popped while empty");
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MWAIT))
        else $error("product arrived outside wait state");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DWAIT))
        else $error("quotient arrived outside wait state");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(DEPTH))
        else $error("sample count beyond ring depth");
    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> !o_empty)
        else $error("finished item not posted");
`endif

endmodule
